// File: src/qpt_pkg.sv
// Shared types, codes and reset constants of the quadrature position tracker.
`default_nettype none
package qpt_pkg;

	localparam int POS_W          = 32;
	localparam int FRACTION_BITS  = 16;
	localparam int MAX_STEPS_DFLT = 3;
	localparam int ADDR_W         = 5;
	localparam int DATA_W         = 32;

	localparam logic signed [POS_W-1:0] STEP_ONE    = POS_W'(1) << FRACTION_BITS;
	localparam logic signed [POS_W-1:0] POS_MIN_RST = {1'b1, {(POS_W-1){1'b0}}};
	localparam logic signed [POS_W-1:0] POS_MAX_RST = {1'b0, {(POS_W-1){1'b1}}};

	typedef enum logic [1:0] {
		CMD_SAMPLE    = 2'd0,
		CMD_NEXT_STEP = 2'd1,
		CMD_RESTART   = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		REG_INITIAL_POS = 3'd0,
		REG_MIN_POS     = 3'd1,
		REG_MAX_POS     = 3'd2,
		REG_REVERSE     = 3'd3,
		REG_STEP_COUNT  = 3'd4,
		REG_STEP_SIZE_0 = 3'd5,
		REG_STEP_SIZE_1 = 3'd6,
		REG_STEP_SIZE_2 = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic signed [POS_W-1:0] init_pos;
		logic signed [POS_W-1:0] pos_lo;
		logic signed [POS_W-1:0] pos_hi;
		logic                    reverse_direction;
		logic [1:0]              step_count;
	} cfg_t;

endpackage
`default_nettype wire

// File: src/qpt_regs.sv
// APB register file holding bounds, direction, step count and step sizes.
`default_nettype none
module qpt_regs
	import qpt_pkg::*;
#(
	parameter int MAX_STEP_SIZES = MAX_STEPS_DFLT
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [ADDR_W-1:0]       paddr,
	input  wire logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]            prdata,
	output logic                         pready,
	output cfg_t                         cfg,
	output logic signed [POS_W-1:0]      step_amt [MAX_STEP_SIZES]
);

	logic     wr_en;
	reg_idx_t idx;
	cfg_t     cfg_q;
	logic signed [POS_W-1:0] step_amt_q [MAX_STEP_SIZES];

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.init_pos          <= '0;
			cfg_q.pos_lo            <= POS_MIN_RST;
			cfg_q.pos_hi            <= POS_MAX_RST;
			cfg_q.reverse_direction <= 1'b0;
			cfg_q.step_count        <= 2'd1;
		end else if (wr_en) begin
			case (idx)
				REG_INITIAL_POS: cfg_q.init_pos          <= pwdata[POS_W-1:0];
				REG_MIN_POS:     cfg_q.pos_lo            <= pwdata[POS_W-1:0];
				REG_MAX_POS:     cfg_q.pos_hi            <= pwdata[POS_W-1:0];
				REG_REVERSE:     cfg_q.reverse_direction <= pwdata[0];
				REG_STEP_COUNT:  cfg_q.step_count        <= pwdata[1:0];
				default: ;
			endcase
		end
	end

	for (genvar i = 0; i < MAX_STEP_SIZES; i++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				step_amt_q[i] <= (i == 0) ? STEP_ONE : '0;
			end else if (wr_en && (idx == reg_idx_t'(3'(REG_STEP_SIZE_0) + 3'(i)))) begin
				step_amt_q[i] <= pwdata[POS_W-1:0];
			end
		end
		assign step_amt[i] = step_amt_q[i];
	end

	// Read back; step size slots beyond the parameter read as zero.
	always_comb begin
		prdata = '0;
		case (idx)
			REG_INITIAL_POS: prdata = DATA_W'(cfg_q.init_pos);
			REG_MIN_POS:     prdata = DATA_W'(cfg_q.pos_lo);
			REG_MAX_POS:     prdata = DATA_W'(cfg_q.pos_hi);
			REG_REVERSE:     prdata = DATA_W'(cfg_q.reverse_direction);
			REG_STEP_COUNT:  prdata = DATA_W'(cfg_q.step_count);
			default: begin
				for (int i = 0; i < MAX_STEP_SIZES; i++) begin
					if (idx == reg_idx_t'(3'(REG_STEP_SIZE_0) + 3'(i))) begin
						prdata = DATA_W'(step_amt_q[i]);
					end
				end
			end
		endcase
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// File: src/qpt_core.sv
// Two-register pipeline: input stage, position/step update and result register.
`default_nettype none
module qpt_core
	import qpt_pkg::*;
#(
	parameter int MAX_STEP_SIZES = MAX_STEPS_DFLT
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire cfg_t                    cfg,
	input  wire logic signed [POS_W-1:0] step_amt [MAX_STEP_SIZES],
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [1:0]              command,
	input  wire logic                    pin_a,
	input  wire logic                    pin_b,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [POS_W-1:0]      position,
	output logic [1:0]                   step_index,
	output logic                         clamped
);

	localparam int IDX_W = (MAX_STEP_SIZES > 1) ? $clog2(MAX_STEP_SIZES) : 1;

	logic                    valid_s1;
	logic [1:0]              command_s1;
	logic                    pin_a_s1;
	logic                    pin_b_s1;
	logic                    adv;

	logic signed [POS_W-1:0] position_q;
	logic                    last_a_q;
	logic [1:0]              step_select_q;
	logic                    out_valid_q;
	logic                    clamped_q;

	logic signed [POS_W-1:0] step;
	logic signed [POS_W:0]   sum;
	logic signed [POS_W-1:0] pos_nxt;
	logic                    clamp_nxt;
	logic                    last_a_nxt;
	logic [1:0]              sel_nxt;
	logic [1:0]              count_use;
	logic [2:0]              sel_inc;
	logic                    up;

	// Move stage 1 into the result register when that register is free or drained.
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			command_s1 <= command;
			pin_a_s1   <= pin_a;
			pin_b_s1   <= pin_b;
		end
	end

	assign step = step_amt[step_select_q[IDX_W-1:0]];
	assign up   = pin_a_s1 ^ pin_b_s1 ^ cfg.reverse_direction;

	always_comb begin
		count_use = (cfg.step_count > 2'(MAX_STEP_SIZES)) ? 2'(MAX_STEP_SIZES)
			: cfg.step_count;
		if (count_use == 2'd0) begin
			count_use = 2'd1;
		end
		sel_inc = {1'b0, step_select_q} + 3'd1;
	end

	always_comb begin
		pos_nxt    = position_q;
		clamp_nxt  = 1'b0;
		last_a_nxt = last_a_q;
		sel_nxt    = step_select_q;
		sum        = {position_q[POS_W-1], position_q};
		case (command_s1)
			CMD_SAMPLE: begin
				if (last_a_q ^ pin_a_s1) begin
					sum = up ? (sum + {step[POS_W-1], step}) : (sum - {step[POS_W-1], step});
				end
				last_a_nxt = pin_a_s1;
				if (sum < $signed({cfg.pos_lo[POS_W-1], cfg.pos_lo})) begin
					pos_nxt   = cfg.pos_lo;
					clamp_nxt = 1'b1;
				end else if (sum > $signed({cfg.pos_hi[POS_W-1], cfg.pos_hi})) begin
					pos_nxt   = cfg.pos_hi;
					clamp_nxt = 1'b1;
				end else begin
					pos_nxt = sum[POS_W-1:0];
				end
			end
			CMD_NEXT_STEP: begin
				case (count_use)
					2'd2:    sel_nxt = {1'b0, sel_inc[0]};
					2'd3:    sel_nxt = (sel_inc == 3'd3) ? 2'd0 : sel_inc[1:0];
					default: sel_nxt = 2'd0;
				endcase
			end
			CMD_RESTART: begin
				pos_nxt    = cfg.init_pos;
				last_a_nxt = pin_a_s1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q    <= '0;
			last_a_q      <= 1'b0;
			step_select_q <= 2'd0;
			out_valid_q   <= 1'b0;
			clamped_q     <= 1'b0;
		end else begin
			if (adv) begin
				position_q    <= pos_nxt;
				last_a_q      <= last_a_nxt;
				step_select_q <= sel_nxt;
				clamped_q     <= clamp_nxt;
				out_valid_q   <= 1'b1;
			end else if (out_ready) begin
				out_valid_q   <= 1'b0;
			end
		end
	end

	// The state registers change only together with the result register,
	// so they double as the position and step index of the held result.
	assign out_valid  = out_valid_q;
	assign position   = position_q;
	assign step_index = step_select_q;
	assign clamped    = clamped_q;

endmodule
`default_nettype wire

// File: src/quadrature_position_tracker.sv
// Top level of the quadrature position tracker: register file and update pipeline.
`default_nettype none
// Quadrature position tracker. Each input transaction carries a command and
// the sampled levels of encoder channels A and B; each one yields exactly one
// output transaction with the Q16.16 position, the selected step index and a
// clamp flag. A pin sample with an edge on A moves the position by the
// selected step size (direction from A, B and reverse_direction), then the
// result is clamped to the lower and upper bound registers, testing the lower
// bound first. "Next step" cycles the step index through the step sizes in use;
// "restart" loads the restart position and takes A as the new reference level.
// Throughput is one transaction per clock unless the output stalls: an input
// register feeds a single 33-bit add and two compares into the result register,
// and the input stage keeps accepting while a result waits, so a stalled output
// costs nothing until both registers are full. A transaction is registered in
// the input register, then in the result register. Write configuration
// over APB (registers at 4*index) only while no transaction is in flight.
module quadrature_position_tracker
	import qpt_pkg::*;
#(
	parameter int MAX_STEP_SIZES = MAX_STEPS_DFLT
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// APB configuration port
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [DATA_W-1:0]  pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready,
	// input channel
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [1:0]         command,
	input  wire logic               pin_a,
	input  wire logic               pin_b,
	// result channel
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic signed [POS_W-1:0] position,
	output logic [1:0]              step_index,
	output logic                    clamped
);

	cfg_t                    cfg;
	logic signed [POS_W-1:0] step_amt [MAX_STEP_SIZES];

	// Hold all configuration; step sizes live in one slot per supported index.
	qpt_regs #(
		.MAX_STEP_SIZES(MAX_STEP_SIZES)
	) u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.cfg       (cfg),
		.step_amt  (step_amt)
	);

	// Advance position, A reference level and step index once per transaction.
	qpt_core #(
		.MAX_STEP_SIZES(MAX_STEP_SIZES)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.step_amt   (step_amt),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.pin_a      (pin_a),
		.pin_b      (pin_b),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.position   (position),
		.step_index (step_index),
		.clamped    (clamped)
	);

endmodule
`default_nettype wire
